// ----- hw/rtl/mbh_pkg.sv -----
// package for the murmur byte hash core: hash constants, sequencer states,
// multiplier control struct and byte mask helper. no dependencies.
package mbh_pkg;

    localparam logic [31:0] M3_C1     = 32'hcc9e2d51;
    localparam logic [31:0] M3_C2     = 32'h1b873593;
    localparam logic [31:0] M3_ADD    = 32'he6546b64;
    localparam logic [31:0] M3_F1     = 32'h85ebca6b;
    localparam logic [31:0] M3_F2     = 32'hc2b2ae35;
    localparam logic [63:0] M64_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned M64_SHIFT = 47;

    localparam logic CFG_HASH_MODE  = 1'b0;
    localparam logic CFG_SEED_VALUE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN_MUL,
        ST_INGEST,
        ST_K1_MUL,
        ST_K2_MUL,
        ST_H_MUL,
        ST_FINAL,
        ST_F1_MUL,
        ST_F2_MUL,
        ST_DONE
    } mbh_state_t;

    typedef struct packed {
        logic go;
        logic wide;
    } mbh_mul_ctl_t;

    // keep bytes below count, zero the rest
    function automatic logic [63:0] low_bytes(input logic [63:0] w, input logic [3:0] n);
        logic [63:0] r;
        r = w;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) >= n)
            begin
                r[i*8 +: 8] = 8'd0;
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mbh_mul.sv -----
// shared multiplier for the murmur byte hash core: one 32x32 multiplier
// stepped over partial products, 64-bit product modulo 2^64. uses mbh_pkg.
module mbh_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbh_pkg::mbh_mul_ctl_t ctl,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    output logic                 done,
    output logic [63:0]          product
);
    import mbh_pkg::*;

    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  last_step;
    logic [31:0] a_part;
    logic [31:0] b_part;
    logic [63:0] pp;

    assign last_step = ctl.wide ? 2'd3 : 2'd1;
    assign done      = ctl.go && (step_reg == last_step);
    assign product   = acc_reg;

    always_comb
    begin
        case (step_reg)
            2'd1:
            begin
                a_part = a[31:0];
                b_part = b[63:32];
            end
            2'd2:
            begin
                a_part = a[63:32];
                b_part = b[31:0];
            end
            default:
            begin
                a_part = a[31:0];
                b_part = b[31:0];
            end
        endcase
        pp = {32'd0, a_part} * {32'd0, b_part};
    end

    always_comb
    begin
        step_next = step_reg;
        acc_next  = acc_reg;
        if (ctl.go)
        begin
            if (done)
            begin
                step_next = 2'd0;
            end
            else
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd0)
                begin
                    acc_next = pp;
                end
                else
                begin
                    acc_next = {acc_reg[63:32] + pp[31:0], acc_reg[31:0]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

// ----- hw/rtl/murmur_byte_hash_core.sv -----
// murmur byte hash core top level: sequencer, hash state, config registers
// and output register. uses mbh_pkg and mbh_mul.
//
// Hashes a little-endian byte message, one word per input transfer, with
// MurmurHash3 x86_32 (hash_mode 0, 4-byte words) or MurmurHash64A (hash_mode
// 1, 8-byte words); the word with first_word set restarts the message and
// brings its length, the word with last_word set finalizes and produces one
// hash_value transfer, and a word outside a message is dropped. All multiplies
// go through one shared 32x32 multiplier, a 64-bit multiply over more partial
// products than a 32-bit one. The core takes one word at a time and takes no
// new word until it is through with the last one, including the finalization
// on a last word. in_ready is high only between words; cfg_ready is always
// high.
module murmur_byte_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [31:0] message_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import mbh_pkg::*;

    mbh_state_t   state_reg;
    mbh_state_t   state_next;
    logic         mode_reg;
    logic [63:0]  seed_reg;
    logic         in_msg_reg;
    logic         in_msg_next;
    logic [63:0]  h_reg;
    logic [63:0]  h_next;
    logic [31:0]  len_reg;
    logic [31:0]  len_next;
    logic [63:0]  word_reg;
    logic [3:0]   count_reg;
    logic         last_reg;
    logic         wide_reg;
    logic [63:0]  opa_reg;
    logic [63:0]  opa_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [63:0]  hash_reg;
    logic         load_out;
    logic         in_xfer;
    logic         wait_out;
    logic [63:0]  tail_bytes;

    mbh_mul_ctl_t mul_ctl;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [63:0]  mul_p_wire;
    logic [63:0]  p;
    logic [31:0]  p32;
    logic [31:0]  h32;
    logic [31:0]  x32;
    logic [31:0]  k32;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign wait_out   = out_valid_reg && !out_ready;
    assign p          = mul_done ? mul_p_wire : 64'd0;

    assign p32        = p[31:0];
    assign h32        = h_reg[31:0];
    assign tail_bytes = low_bytes(word_reg, count_reg);

    mbh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .a       (opa_reg),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p_wire)
    );

    always_comb
    begin
        mul_ctl.wide = wide_reg;
        mul_ctl.go   = (state_reg == ST_LEN_MUL) || (state_reg == ST_K1_MUL) ||
                       (state_reg == ST_K2_MUL) || (state_reg == ST_H_MUL) ||
                       (state_reg == ST_F1_MUL) || (state_reg == ST_F2_MUL);
        case (state_reg)
            ST_K1_MUL: mul_b = wide_reg ? M64_MUL : {32'd0, M3_C1};
            ST_K2_MUL: mul_b = wide_reg ? M64_MUL : {32'd0, M3_C2};
            ST_F1_MUL: mul_b = wide_reg ? M64_MUL : {32'd0, M3_F1};
            ST_F2_MUL: mul_b = {32'd0, M3_F2};
            default:   mul_b = M64_MUL;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (first_word && mode_reg)
                    begin
                        state_next = ST_LEN_MUL;
                    end
                    else if (first_word || in_msg_reg)
                    begin
                        state_next = ST_INGEST;
                    end
                end
            end
            ST_LEN_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_INGEST;
                end
            end
            ST_INGEST:
            begin
                if (count_reg == 4'd0)
                begin
                    state_next = ST_FINAL;
                end
                else if (wide_reg && count_reg < 4'd8)
                begin
                    state_next = ST_H_MUL;
                end
                else
                begin
                    state_next = ST_K1_MUL;
                end
            end
            ST_K1_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_K2_MUL;
                end
            end
            ST_K2_MUL:
            begin
                if (mul_done)
                begin
                    state_next = wide_reg ? ST_H_MUL : ST_FINAL;
                end
            end
            ST_H_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = last_reg ? ST_F1_MUL : ST_IDLE;
            end
            ST_F1_MUL:
            begin
                if (mul_done)
                begin
                    state_next = wide_reg ? ST_DONE : ST_F2_MUL;
                end
            end
            ST_F2_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!wait_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        h_next      = h_reg;
        opa_next    = opa_reg;
        len_next    = len_reg;
        in_msg_next = in_msg_reg;
        load_out    = 1'b0;
        x32         = h32 ^ p32;
        k32         = 32'd0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && first_word)
                begin
                    len_next    = message_length;
                    in_msg_next = 1'b1;
                    if (mode_reg)
                    begin
                        opa_next = {32'd0, message_length};
                    end
                    else
                    begin
                        h_next = {32'd0, seed_reg[31:0]};
                    end
                end
            end
            ST_LEN_MUL:
            begin
                if (mul_done)
                begin
                    h_next = seed_reg ^ p;
                end
            end
            ST_INGEST:
            begin
                if (wide_reg)
                begin
                    if (count_reg >= 4'd8)
                    begin
                        opa_next = word_reg;
                    end
                    else
                    begin
                        opa_next = h_reg ^ tail_bytes;
                    end
                end
                else
                begin
                    h_next = {32'd0, h32};
                    if (count_reg >= 4'd4)
                    begin
                        opa_next = {32'd0, word_reg[31:0]};
                    end
                    else
                    begin
                        opa_next = {32'd0, tail_bytes[31:0]};
                    end
                end
            end
            ST_K1_MUL:
            begin
                if (mul_done)
                begin
                    if (wide_reg)
                    begin
                        opa_next = p ^ (p >> M64_SHIFT);
                    end
                    else
                    begin
                        opa_next = {32'd0, p32[16:0], p32[31:17]};
                    end
                end
            end
            ST_K2_MUL:
            begin
                if (mul_done)
                begin
                    if (wide_reg)
                    begin
                        opa_next = h_reg ^ p;
                    end
                    else if (count_reg >= 4'd4)
                    begin
                        k32    = {x32[18:0], x32[31:19]};
                        h_next = {32'd0, k32 + {k32[29:0], 2'b00} + M3_ADD};
                    end
                    else
                    begin
                        h_next = {32'd0, x32};
                    end
                end
            end
            ST_H_MUL:
            begin
                if (mul_done)
                begin
                    h_next = p;
                end
            end
            ST_FINAL:
            begin
                if (last_reg)
                begin
                    if (wide_reg)
                    begin
                        opa_next = h_reg ^ (h_reg >> M64_SHIFT);
                    end
                    else
                    begin
                        k32      = h32 ^ len_reg;
                        opa_next = {32'd0, k32 ^ {16'd0, k32[31:16]}};
                    end
                end
            end
            ST_F1_MUL:
            begin
                if (mul_done)
                begin
                    if (wide_reg)
                    begin
                        h_next = p ^ (p >> M64_SHIFT);
                    end
                    else
                    begin
                        opa_next = {32'd0, p32 ^ {13'd0, p32[31:13]}};
                    end
                end
            end
            ST_F2_MUL:
            begin
                if (mul_done)
                begin
                    h_next = {32'd0, p32 ^ {16'd0, p32[31:16]}};
                end
            end
            ST_DONE:
            begin
                if (!wait_out)
                begin
                    load_out    = 1'b1;
                    in_msg_next = 1'b0;
                end
            end
            default:
            begin
                h_next = h_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            seed_reg      <= 64'd0;
            in_msg_reg    <= 1'b0;
            h_reg         <= 64'd0;
            len_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            h_reg         <= h_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HASH_MODE:  mode_reg <= cfg_data[0];
                    CFG_SEED_VALUE: seed_reg <= cfg_data;
                    default:        seed_reg <= seed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        if (in_xfer)
        begin
            word_reg  <= data_word;
            count_reg <= byte_count;
            last_reg  <= last_word;
            wide_reg  <= mode_reg;
        end
        if (load_out)
        begin
            hash_reg <= h_reg;
        end
    end

endmodule
